>>> hw/rtl/cpbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpbe_pkg
// Shared types, constants and helpers of the palette color blend engine.
// ----------------------------------------------------------------------------
package cpbe_pkg;

  localparam int unsigned CHAN_W      = 16;
  localparam int unsigned LEVEL_W     = 17;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned INDEX_W     = 3;
  localparam int unsigned NCHAN       = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CHAN_W-1:0] LFSR_TAPS  = 16'hb400;
  localparam logic [CHAN_W-1:0] LFSR_SEED  = 16'h0001;
  localparam logic [CHAN_W-1:0] HALF_SCALE = 16'h8000;
  localparam logic [CHAN_W-1:0] FULL_CHAN  = 16'hffff;

  typedef enum logic [MODE_W-1:0] {
    MODE_TINT   = 3'd0,
    MODE_STATIC = 3'd1,
    MODE_NEGATE = 3'd2,
    MODE_DODGE  = 3'd3,
    MODE_BURN   = 3'd4,
    MODE_SOFT   = 3'd5
  } blend_mode_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_RED   = 3'd1,
    REG_GREEN = 3'd2,
    REG_BLUE  = 3'd3,
    REG_LEVEL = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_MIX,
    ST_FIN
  } back_state_t;

  typedef struct packed {
    logic [MODE_W-1:0]             mode;
    logic [NCHAN-1:0][CHAN_W-1:0]  color;
    logic [LEVEL_W-1:0]            level;
  } cfg_t;

  // one queued entry: classified and with its noise already drawn
  typedef struct packed {
    logic [MODE_W-1:0]             mode;
    logic [NCHAN-1:0][CHAN_W-1:0]  orig;
    logic [NCHAN-1:0][CHAN_W-1:0]  noise;
    logic [7:0]                    inten;
  } cpbe_item_t;

  function automatic logic [CHAN_W-1:0] lfsr_step(input logic [CHAN_W-1:0] s);
    lfsr_step = s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
  endfunction

  function automatic logic [CHAN_W-1:0] clamp16(input logic signed [19:0] v);
    if (v < 20'sd0) begin
      clamp16 = '0;
    end else if (v > 20'sd65535) begin
      clamp16 = FULL_CHAN;
    end else begin
      clamp16 = v[CHAN_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cpbe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpbe_front
// Accepts palette entries, draws static noise from the lfsr and finds the
// brightest channel, then hands the entry to the queue.
// ----------------------------------------------------------------------------
module cpbe_front import cpbe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic              q_full,
  input  wire logic [CHAN_W-1:0] red_in,
  input  wire logic [CHAN_W-1:0] green_in,
  input  wire logic [CHAN_W-1:0] blue_in,
  input  wire cfg_t              cfg,
  output logic                   q_push,
  output cpbe_item_t             q_item
);

  logic [CHAN_W-1:0] noise_lfsr;
  logic [CHAN_W-1:0] step1, step2, step3;
  logic [CHAN_W-1:0] lvl_sat, mask, mx;

  assign q_push = push && !q_full;

  assign step1 = lfsr_step(noise_lfsr);
  assign step2 = lfsr_step(step1);
  assign step3 = lfsr_step(step2);

  always_comb begin
    lvl_sat = (cfg.level > {1'b0, FULL_CHAN}) ? FULL_CHAN : cfg.level[CHAN_W-1:0];
    // smear the top set bit down to bit 0
    mask = lvl_sat | (lvl_sat >> 1);
    mask = mask | (mask >> 2);
    mask = mask | (mask >> 4);
    mask = mask | (mask >> 8);
    mx = red_in;
    if (green_in > mx) begin
      mx = green_in;
    end
    if (blue_in > mx) begin
      mx = blue_in;
    end
  end

  always_comb begin
    q_item.mode     = cfg.mode;
    q_item.orig[0]  = red_in;
    q_item.orig[1]  = green_in;
    q_item.orig[2]  = blue_in;
    q_item.noise[0] = step1 & mask;
    q_item.noise[1] = step2 & mask;
    q_item.noise[2] = step3 & mask;
    q_item.inten    = mx[CHAN_W-1:8];
  end

  // noise only advances on static beats
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_lfsr <= LFSR_SEED;
    end else if (q_push && cfg.mode == MODE_STATIC) begin
      noise_lfsr <= step3;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/cpbe_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpbe_fifo
// Short queue of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module cpbe_fifo import cpbe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire cpbe_item_t din,
  input  wire logic       pop,
  output cpbe_item_t      dout,
  output logic            full,
  output logic            empty
);

  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);

  cpbe_item_t         mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full  = (count == COUNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != COUNT_W'(QUEUE_DEPTH))
    else $error("push into full queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

endmodule
`default_nettype wire

>>> hw/rtl/cpbe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpbe_back
// Blend sequencer: one product stage, one mix stage, one finish stage per
// entry, three channel lanes side by side, result held in an output register.
// ----------------------------------------------------------------------------
module cpbe_back import cpbe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire cpbe_item_t        q_item,
  input  wire cfg_t              cfg,
  input  wire logic              pop,
  output logic                   q_pop,
  output logic                   empty,
  output logic [CHAN_W-1:0]      red_out,
  output logic [CHAN_W-1:0]      green_out,
  output logic [CHAN_W-1:0]      blue_out
);

  back_state_t state, state_next;

  cpbe_item_t                   op;
  logic [NCHAN-1:0][31:0]       prod;
  logic signed [26:0]           mixp [NCHAN];
  logic [NCHAN-1:0][CHAN_W-1:0] res;
  logic [NCHAN-1:0][CHAN_W-1:0] fin;
  logic                         out_valid;
  logic                         res_free;
  logic                         load_op, load_mul, load_mix, load_res;

  assign res_free = !out_valid || pop;

  function automatic logic [CHAN_W-1:0] finish(
    input logic [MODE_W-1:0]  mode,
    input logic [CHAN_W-1:0]  o,
    input logic [CHAN_W-1:0]  c,
    input logic [CHAN_W-1:0]  noise,
    input logic [31:0]        p,
    input logic signed [26:0] mp,
    input logic [LEVEL_W-1:0] lvl
  );
    logic signed [19:0] so, sx, st, sp, sl, v;
    logic signed [26:0] sh;
    logic [CHAN_W-1:0]  r;
    so = $signed({4'b0, o});
    sx = $signed({4'b0, o ^ c});
    sl = $signed({3'b0, lvl});
    sp = $signed({4'b0, p[31:16]});
    st = 20'sd65536 - sl;
    sh = mp >>> 8;
    v  = so;
    r  = o;
    case (mode)
      MODE_TINT, MODE_SOFT: begin
        v = so + $signed(sh[19:0]);
        r = clamp16(v);
      end
      MODE_NEGATE: begin
        if (o > HALF_SCALE) begin
          v = sx + st;
          if (v > so) begin
            v = so;
          end
        end else begin
          v = sx - st;
          if (v < so) begin
            v = so;
          end
        end
        r = clamp16(v);
      end
      MODE_DODGE: begin
        v = 20'sd65535 - sp - sl;
        if (v > so) begin
          v = so;
        end
        r = clamp16(v);
      end
      MODE_BURN: begin
        v = sp + 20'sd65536 - sl;
        if (v > so) begin
          v = so;
        end
        r = clamp16(v);
      end
      MODE_STATIC: begin
        r = o + noise;
      end
      default: begin
        r = o;
      end
    endcase
    finish = r;
  endfunction

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_MIX;
      ST_MIX: state_next = ST_FIN;
      ST_FIN: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // stage controls
  always_comb begin
    load_op  = 1'b0;
    load_mul = 1'b0;
    load_mix = 1'b0;
    load_res = 1'b0;
    case (state)
      ST_IDLE: load_op  = !q_empty;
      ST_MUL:  load_mul = 1'b1;
      ST_MIX:  load_mix = 1'b1;
      ST_FIN:  load_res = res_free;
      default: ;
    endcase
  end

  assign q_pop = load_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_op) begin
      op <= q_item;
    end
  end

  // product stage: soft tint scales the color, dodge and burn multiply
  always_ff @(posedge clk) begin
    if (load_mul) begin
      for (int i = 0; i < NCHAN; i++) begin
        prod[i] <= 32'((op.mode == MODE_DODGE) ? (cfg.color[i] ^ FULL_CHAN) : cfg.color[i])
                 * 32'((op.mode == MODE_SOFT) ? {8'b0, op.inten} : op.orig[i]);
      end
    end
  end

  // mix stage: (target - orig) * level
  always_ff @(posedge clk) begin
    if (load_mix) begin
      for (int i = 0; i < NCHAN; i++) begin
        mixp[i] <= 27'($signed({1'b0, ((op.mode == MODE_SOFT) ? prod[i][23:8] : cfg.color[i])})
                      - $signed({1'b0, op.orig[i]}))
                 * 27'($signed({1'b0, cfg.level[LEVEL_W-1:8]}));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NCHAN; i++) begin
      fin[i] = finish(op.mode, op.orig[i], cfg.color[i], op.noise[i], prod[i], mixp[i],
                      cfg.level);
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_res) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty     = !out_valid;
  assign red_out   = res[0];
  assign green_out = res[1];
  assign blue_out  = res[2];

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && res_free |=> out_valid && state == ST_IDLE)
    else $error("finished beat not delivered");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_res |-> !out_valid || pop)
    else $error("result overwritten before pop");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ST_IDLE && !q_empty)
    else $error("queue popped outside idle");

endmodule
`default_nettype wire

>>> hw/rtl/palette_color_blend_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_color_blend_engine
// Blends 16-bit RGB palette entries with a configured color by mode and level.
// ----------------------------------------------------------------------------
// Input side is a queue: drive red_in/green_in/blue_in with push; a beat is
// taken on a clock edge with push high and full low. Results come out as a
// queue: while empty is low the oldest result sits on red_out/green_out/
// blue_out and pop takes it.
// Registers are written through cfg_valid/cfg_ready (ready is always high),
// cfg_index selects mode, red, green, blue, level; other indexes are dropped.
// Write them only while no entry is in flight.
// The back-end sequencer fetches an entry from the queue and runs it through
// product, mix and finish steps; it takes no new entry until the last result is in
// the output register, and a 2-entry queue in front lets push run ahead.
// If pop is held low the finished result waits in the output register, the
// back end stalls in its finish step, the queue fills and full rises.
// Reset clears the config registers and both queues, and sets the noise lfsr to 1.
// ----------------------------------------------------------------------------
module palette_color_blend_engine import cpbe_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [CHAN_W-1:0]  red_in,
  input  wire logic [CHAN_W-1:0]  green_in,
  input  wire logic [CHAN_W-1:0]  blue_in,
  output logic                    empty,
  input  wire logic               pop,
  output logic [CHAN_W-1:0]       red_out,
  output logic [CHAN_W-1:0]       green_out,
  output logic [CHAN_W-1:0]       blue_out,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [INDEX_W-1:0] cfg_index,
  input  wire logic [LEVEL_W-1:0] cfg_data
);

  cfg_t       cfg;
  logic       q_push, q_pop, q_full, q_empty;
  cpbe_item_t q_din, q_dout;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:  cfg.mode     <= cfg_data[MODE_W-1:0];
        REG_RED:   cfg.color[0] <= cfg_data[CHAN_W-1:0];
        REG_GREEN: cfg.color[1] <= cfg_data[CHAN_W-1:0];
        REG_BLUE:  cfg.color[2] <= cfg_data[CHAN_W-1:0];
        REG_LEVEL: cfg.level    <= cfg_data;
        default: ;
      endcase
    end
  end

  cpbe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .q_full   (q_full),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .cfg      (cfg),
    .q_push   (q_push),
    .q_item   (q_din)
  );

  cpbe_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  cpbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_dout),
    .cfg       (cfg),
    .pop       (pop),
    .q_pop     (q_pop),
    .empty     (empty),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

endmodule
`default_nettype wire

>>> tb/sv/tb_palette_color_blend_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_color_blend_engine
// Streams palette entries through the blend engine under a series of mode,
// color and level settings, and compares every blended entry with a fixed value
// or a local model of the blend math and noise lfsr. Both queue sides idle at random.
// ----------------------------------------------------------------------------
module tb_palette_color_blend_engine;
  import cpbe_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int NUM_PHASES   = 16;
  localparam int JUNK_ROW     = 2;
  localparam int NUM_PROBES   = 25;

  // modes with no blend behind them: entry passes through
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 17'h10000;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 17'h1ffff;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    rgb_t               color;
    logic [LEVEL_W-1:0] level;
    rgb_t               entry;
    logic               typed;
    rgb_t               want;
  } probe_t;

  localparam probe_t PROBES [NUM_PROBES] = '{
    '{MODE_TINT, '{16'h0000, 16'h0000, 16'h0000}, 17'h00000,
      '{16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
    '{MODE_TINT, '{16'h0000, 16'h0000, 16'h0000}, 17'h00000,
      '{16'hffff, 16'h8000, 16'h1234}, 1'b1, '{16'hffff, 16'h8000, 16'h1234}},
    '{MODE_TINT, '{16'h0000, 16'h0000, 16'h0000}, 17'h00000,
      '{16'ha5a5, 16'h5a5a, 16'hffff}, 1'b1, '{16'ha5a5, 16'h5a5a, 16'hffff}},
    '{MODE_TINT, '{16'h1111, 16'h2222, 16'h3333}, LEVEL_FULL,
      '{16'hffff, 16'h0000, 16'h8000}, 1'b1, '{16'h1111, 16'h2222, 16'h3333}},
    '{MODE_TINT, '{16'h1111, 16'hfedc, 16'h7fff}, 17'h08000,
      '{16'h0000, 16'hffff, 16'h4000}, 1'b0, '0},
    '{MODE_TINT, '{16'hffff, 16'h0000, 16'h8000}, LEVEL_MAX,
      '{16'h0000, 16'hffff, 16'h8000}, 1'b1, '{16'hffff, 16'h0000, 16'h8000}},
    '{MODE_STATIC, '{16'h0000, 16'h0000, 16'h0000}, 17'h00000,
      '{16'h1234, 16'h5678, 16'h9abc}, 1'b1, '{16'h1234, 16'h5678, 16'h9abc}},
    '{MODE_STATIC, '{16'h0000, 16'h0000, 16'h0000}, 17'h0ffff,
      '{16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{MODE_STATIC, '{16'h0000, 16'h0000, 16'h0000}, LEVEL_MAX,
      '{16'hffff, 16'hffff, 16'hffff}, 1'b0, '0},
    '{MODE_STATIC, '{16'h0000, 16'h0000, 16'h0000}, 17'h00001,
      '{16'hfffe, 16'hffff, 16'h0001}, 1'b0, '0},
    '{MODE_NEGATE, '{16'hffff, 16'h0000, 16'h8000}, LEVEL_FULL,
      '{16'h8000, 16'h8001, 16'h0000}, 1'b0, '0},
    '{MODE_NEGATE, '{16'hffff, 16'h0000, 16'h8000}, 17'h00000,
      '{16'hffff, 16'h0000, 16'h1234}, 1'b0, '0},
    '{MODE_NEGATE, '{16'h5555, 16'haaaa, 16'hffff}, LEVEL_MAX,
      '{16'h8001, 16'h7fff, 16'hffff}, 1'b0, '0},
    '{MODE_DODGE, '{16'hffff, 16'hffff, 16'hffff}, 17'h00000,
      '{16'hffff, 16'h0000, 16'h8000}, 1'b1, '{16'hffff, 16'h0000, 16'h8000}},
    '{MODE_DODGE, '{16'h0000, 16'h0000, 16'h0000}, LEVEL_FULL,
      '{16'hffff, 16'h8000, 16'h0001}, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
    '{MODE_DODGE, '{16'h1234, 16'h8000, 16'hfff0}, LEVEL_MAX,
      '{16'h9876, 16'hffff, 16'h0100}, 1'b0, '0},
    '{MODE_BURN, '{16'h0000, 16'h0000, 16'h0000}, LEVEL_FULL,
      '{16'hffff, 16'h8000, 16'h0001}, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
    '{MODE_BURN, '{16'hffff, 16'hffff, 16'hffff}, 17'h00000,
      '{16'hffff, 16'h0000, 16'h8000}, 1'b1, '{16'hffff, 16'h0000, 16'h8000}},
    '{MODE_BURN, '{16'hffff, 16'h8000, 16'h0001}, LEVEL_MAX,
      '{16'hffff, 16'hc000, 16'h7777}, 1'b0, '0},
    '{MODE_SOFT, '{16'hffff, 16'h8000, 16'h0001}, LEVEL_FULL,
      '{16'hffff, 16'h0000, 16'h0000}, 1'b0, '0},
    '{MODE_SOFT, '{16'hffff, 16'hffff, 16'hffff}, LEVEL_MAX,
      '{16'h0000, 16'h0000, 16'hffff}, 1'b0, '0},
    '{MODE_SOFT, '{16'h4321, 16'h0f0f, 16'hf00f}, 17'h08000,
      '{16'h1234, 16'h5678, 16'h9abc}, 1'b0, '0},
    '{MODE_SPARE6, '{16'h4321, 16'h0f0f, 16'hf00f}, LEVEL_FULL,
      '{16'hdead, 16'hbeef, 16'hffff}, 1'b1, '{16'hdead, 16'hbeef, 16'hffff}},
    '{MODE_SPARE7, '{16'hffff, 16'h0000, 16'h8000}, LEVEL_MAX,
      '{16'h0000, 16'h0001, 16'hfffe}, 1'b1, '{16'h0000, 16'h0001, 16'hfffe}},
    '{MODE_STATIC, '{16'h0000, 16'h0000, 16'h0000}, 17'h000ff,
      '{16'h8000, 16'h7fff, 16'hff00}, 1'b0, '0}
  };

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               push      = 1'b0;
  logic               full;
  logic [CHAN_W-1:0]  red_in    = '0;
  logic [CHAN_W-1:0]  green_in  = '0;
  logic [CHAN_W-1:0]  blue_in   = '0;
  logic               empty;
  logic               pop       = 1'b0;
  logic [CHAN_W-1:0]  red_out;
  logic [CHAN_W-1:0]  green_out;
  logic [CHAN_W-1:0]  blue_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [LEVEL_W-1:0] cfg_data  = '0;

  // register copies as the block should hold them
  logic [MODE_W-1:0]  cur_mode    = MODE_TINT;
  logic [CHAN_W-1:0]  cur_red     = '0;
  logic [CHAN_W-1:0]  cur_green   = '0;
  logic [CHAN_W-1:0]  cur_blue    = '0;
  logic [LEVEL_W-1:0] cur_level   = '0;
  logic [CHAN_W-1:0]  noise_state = LFSR_SEED;

  rgb_t blended_q [$];
  int   bad_results = 0;
  int   tx_calm     = 0;
  int   rx_calm     = 0;
  int   cycle_cnt   = 0;

  palette_color_blend_engine dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .empty     (empty),
    .pop       (pop),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CHAN_W-1:0] sat_chan(input longint v);
    if (v < 0) return '0;
    if (v > 65535) return FULL_CHAN;
    return v[CHAN_W-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] next_noise(input logic [CHAN_W-1:0] s);
    return s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
  endfunction

  function automatic logic [CHAN_W-1:0] blend_chan(input longint o, input longint c,
                                                   input longint inten);
    longint lvl, l8, t, v, s;
    lvl = longint'(cur_level);
    l8  = lvl >>> 8;
    case (cur_mode)
      MODE_TINT: begin
        return sat_chan(o + (((c - o) * l8) >>> 8));
      end
      MODE_NEGATE: begin
        t = 65536 - lvl;
        if (o > longint'(HALF_SCALE)) begin
          v = (o ^ c) + t;
          if (v > o) v = o;
        end else begin
          v = (o ^ c) - t;
          if (v < o) v = o;
        end
        return sat_chan(v);
      end
      MODE_DODGE: begin
        v = 65535 - (((c ^ 65535) * o) >> 16) - lvl;
        if (v > o) v = o;
        return sat_chan(v);
      end
      MODE_BURN: begin
        v = ((c * o) >> 16) + 65536 - lvl;
        if (v > o) v = o;
        return sat_chan(v);
      end
      MODE_SOFT: begin
        s = (c * inten) >> 8;
        return sat_chan(o + (((s - o) * l8) >>> 8));
      end
      default: begin
        return o[CHAN_W-1:0];
      end
    endcase
  endfunction

  // expected blended entry; steps the noise lfsr in static mode
  function automatic rgb_t blend_entry(input rgb_t o);
    rgb_t              res;
    logic [CHAN_W-1:0] lvl, m;
    longint            mx;
    if (cur_mode == MODE_STATIC) begin
      lvl = (cur_level > 17'h0ffff) ? FULL_CHAN : cur_level[CHAN_W-1:0];
      m = '0;
      while ((~m & lvl) != '0) m = {m[CHAN_W-2:0], 1'b1};
      noise_state = next_noise(noise_state);
      res.red     = o.red + (noise_state & m);
      noise_state = next_noise(noise_state);
      res.green   = o.green + (noise_state & m);
      noise_state = next_noise(noise_state);
      res.blue    = o.blue + (noise_state & m);
    end else begin
      mx = o.red;
      if (o.green > mx) mx = o.green;
      if (o.blue > mx) mx = o.blue;
      mx = mx >> 8;
      res.red   = blend_chan(o.red, cur_red, mx);
      res.green = blend_chan(o.green, cur_green, mx);
      res.blue  = blend_chan(o.blue, cur_blue, mx);
    end
    return res;
  endfunction

  // idle cycles before the next beat, with runs of back-to-back beats
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return FULL_CHAN;
      2: return HALF_SCALE;
      3: return HALF_SCALE + 16'h1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return LEVEL_FULL;
      2: return LEVEL_MAX;
      3: return 17'h0ffff;
      4: return 17'h00100;
      5: return 17'($urandom);
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [LEVEL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:  cur_mode  = data[MODE_W-1:0];
      REG_RED:   cur_red   = data[CHAN_W-1:0];
      REG_GREEN: cur_green = data[CHAN_W-1:0];
      REG_BLUE:  cur_blue  = data[CHAN_W-1:0];
      REG_LEVEL: cur_level = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk); while (blended_q.size() != 0);
  endtask

  task automatic set_config(input logic [MODE_W-1:0] m, input rgb_t c,
                            input logic [LEVEL_W-1:0] lvl, input bit every, input bit junk);
    bit wrote;
    int k;
    wrote = every || junk || m != cur_mode || c.red != cur_red || c.green != cur_green ||
            c.blue != cur_blue || lvl != cur_level;
    if (wrote) wait_idle();
    // upper data bits are noise the register has to drop
    if (every || m != cur_mode) write_reg(REG_MODE, {14'($urandom), m});
    if (every || c.red != cur_red) write_reg(REG_RED, {1'($urandom), c.red});
    if (every || c.green != cur_green) write_reg(REG_GREEN, {1'($urandom), c.green});
    if (every || c.blue != cur_blue) write_reg(REG_BLUE, {1'($urandom), c.blue});
    if (every || lvl != cur_level) write_reg(REG_LEVEL, lvl);
    if (junk) begin
      for (k = int'(REG_LEVEL) + 1; k < (1 << INDEX_W); k++) begin
        write_reg(k[INDEX_W-1:0], 17'($urandom));
      end
    end
    if (wrote) cfg_valid <= 1'b0;
  endtask

  // push stays high on return so a zero gap keeps beats back to back
  task automatic send_entry(input rgb_t e, input bit typed, input rgb_t want);
    rgb_t guess;
    int   gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    red_in   <= e.red;
    green_in <= e.green;
    blue_in  <= e.blue;
    do @(posedge clk); while (full);
    guess = blend_entry(e);
    blended_q.push_back(typed ? want : guess);
  endtask

  initial begin : result_side
    rgb_t got, want;
    int   stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait(rx_calm);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got = '{red_out, green_out, blue_out};
      if (blended_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("unexpected beat: got %h %h %h", got.red, got.green, got.blue);
        end
      end else begin
        want = blended_q.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("mismatch: expected %h %h %h, got %h %h %h",
                     want.red, want.green, want.blue, got.red, got.green, got.blue);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int                 i, ph, n, cnt;
    logic [MODE_W-1:0]  m;
    rgb_t               c, e;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // the first rows run on reset values; the third follows writes to unused indexes
    for (i = 0; i < NUM_PROBES; i++) begin
      set_config(PROBES[i].mode, PROBES[i].color, PROBES[i].level, 1'b0, i == JUNK_ROW);
      send_entry(PROBES[i].entry, PROBES[i].typed, PROBES[i].want);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      m = (ph < (1 << MODE_W)) ? ph[MODE_W-1:0] : MODE_W'($urandom_range(0, 7));
      c = '{rand_chan(), rand_chan(), rand_chan()};
      set_config(m, c, rand_level(), 1'b1, 1'b0);
      cnt = $urandom_range(25, 45);
      for (n = 0; n < cnt; n++) begin
        if ($urandom_range(0, 199) == 0) wait_idle();
        e = '{rand_chan(), rand_chan(), rand_chan()};
        send_entry(e, 1'b0, '0);
      end
    end
    push <= 1'b0;

    while (blended_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0 && blended_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
